// ===== rtl/vvtc_pkg.sv =====
// Package: shared types, constants and helpers for the vertex view transform and clip block.
package vvtc_pkg;

  // Number format
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_WIDTH  = 32;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SUM_W      = DATA_WIDTH + 2;
  localparam int CMP_W      = ((DATA_WIDTH > CFG_WIDTH) ? DATA_WIDTH : CFG_WIDTH) + 1;
  localparam longint DMAX   = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam longint DMIN   = -DMAX - 1;

  // Coefficient table layout: rows of three coefficients
  localparam int NUM_COEF = 24;
  localparam int LANES    = 3;
  localparam int ROWS     = NUM_COEF / LANES;
  localparam int IDX_W    = 5;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int LANE_W   = $clog2(LANES);
  localparam logic [ROW_W-1:0] ROW_OBJ  = ROW_W'(0);
  localparam logic [ROW_W-1:0] ROW_OPOS = ROW_W'(3);
  localparam logic [ROW_W-1:0] ROW_VIEW = ROW_W'(4);
  localparam logic [ROW_W-1:0] ROW_VPOS = ROW_W'(7);

  // Clip outcode
  localparam int CLIP_W = 6;
  localparam logic [CLIP_W-1:0] ALL_CLIP    = '1;
  localparam int CLIP_BEHIND = 0;
  localparam int CLIP_FAR    = 1;
  localparam int CLIP_RIGHT  = 2;
  localparam int CLIP_LEFT   = 3;
  localparam int CLIP_BOTTOM = 4;
  localparam int CLIP_TOP    = 5;

  // Input operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_Z         = 2'd0,
    CFG_FAR_Z          = 2'd1,
    CFG_TRANSLATE_ONLY = 2'd2
  } cfg_idx_e;

  // Sequencer steps of one point
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_OPOS = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_VPOS = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_WRD  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_WMUL = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_WTRM = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_WSUM = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_VRD  = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_VMUL = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_VTRM = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_VSUM = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_CLIP = STEP_W'(13);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // Control from the sequencer to the row unit
  typedef struct packed {
    logic              mul_en;
    logic              term_en;
    logic              pass_en;
    logic [LANE_W-1:0] pass_lane;
  } row_ctl_t;

  // Map a coefficient index to its table row and lane
  function automatic logic [ROW_W-1:0] coef_row(logic [IDX_W-1:0] idx);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int i = 1; i < ROWS; i++) begin
      if (idx >= IDX_W'(i * LANES)) r = ROW_W'(i);
    end
    return r;
  endfunction

  function automatic logic [LANE_W-1:0] coef_lane(logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] base;
    base = IDX_W'(coef_row(idx)) * IDX_W'(LANES);
    return LANE_W'(idx - base);
  endfunction

endpackage

// ===== rtl/vvtc_if.sv =====
// Interfaces: point/load input channel, result channel and configuration write channel.
interface vvtc_in_if;
  import vvtc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [IDX_W-1:0]       coef_index;
  logic signed [DATA_WIDTH-1:0] coef_value;
  logic signed [DATA_WIDTH-1:0] px;
  logic signed [DATA_WIDTH-1:0] py;
  logic signed [DATA_WIDTH-1:0] pz;
  logic                   last_point;

  modport source (output valid, op, coef_index, coef_value, px, py, pz, last_point,
                  input ready);
  modport sink   (input valid, op, coef_index, coef_value, px, py, pz, last_point,
                  output ready);
endinterface

interface vvtc_out_if;
  import vvtc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [DATA_WIDTH-1:0] view_x;
  logic signed [DATA_WIDTH-1:0] view_y;
  logic signed [DATA_WIDTH-1:0] view_z;
  logic [CLIP_W-1:0]      clip_code;
  logic                   pool_visible;
  logic                   last_out;

  modport source (output valid, view_x, view_y, view_z, clip_code, pool_visible, last_out,
                  input ready);
  modport sink   (input valid, view_x, view_y, view_z, clip_code, pool_visible, last_out,
                  output ready);
endinterface

interface vvtc_cfg_if;
  import vvtc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/vvtc_coef_mem.sv =====
// Coefficient memory: rows of three coefficients, lane writes, registered row read.
module vvtc_coef_mem
  import vvtc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ROW_W-1:0]  wr_row_i,
  input  logic [LANE_W-1:0] wr_lane_i,
  input  data_t             wr_data_i,
  input  logic              rd_en_i,
  input  logic [ROW_W-1:0]  rd_row_i,
  output data_t             rd_data_o [LANES]
);

  data_t mem_q [ROWS][LANES];
  data_t rd_q [LANES];
  logic [ROWS-1:0][LANES-1:0] vld_q;
  logic [LANES-1:0] rd_vld_q;

  // Write one lane, read one whole row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_row_i][wr_lane_i] <= wr_data_i;
    if (rd_en_i) rd_q <= mem_q[rd_row_i];
  end

  // Track written entries; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= '0;
    end else begin
      if (wr_en_i) vld_q[wr_row_i][wr_lane_i] <= 1'b1;
      if (rd_en_i) rd_vld_q <= vld_q[rd_row_i];
    end
  end

  // Mask lanes never written since reset
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      rd_data_o[j] = rd_vld_q[j] ? rd_q[j] : '0;
    end
  end

endmodule

// ===== rtl/vvtc_row_unit.sv =====
// Row unit: three multipliers, fixed-point rescale with saturation, and row sum.
module vvtc_row_unit
  import vvtc_pkg::*;
(
  input  logic     clk_i,
  input  row_ctl_t ctl_i,
  input  data_t    coef_i [LANES],
  input  data_t    opnd_i [LANES],
  input  data_t    add_i,
  input  data_t    sub_i,
  output data_t    res_o
);

  localparam int SCL_W = PROD_W - FRAC_BITS;
  localparam logic signed [PROD_W-1:0] FRAC_ONES =
      PROD_W'((longint'(1) << FRAC_BITS) - 1);

  logic signed [PROD_W-1:0] prod_q [LANES];
  data_t term_q [LANES];
  data_t term_d [LANES];
  logic signed [SUM_W-1:0] sum_w;
  logic signed [SUM_W-1:0] diff_w;
  data_t row_sat;

  // Drop fraction bits toward zero, then clamp to the data range
  function automatic data_t scale_sat(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    logic signed [SCL_W-1:0] q;
    biased = p + (p[PROD_W-1] ? FRAC_ONES : '0);
    q = SCL_W'(biased >>> FRAC_BITS);
    if (q > SCL_W'(DMAX)) return data_t'(DMAX);
    if (q < SCL_W'(DMIN)) return data_t'(DMIN);
    return DATA_WIDTH'(q);
  endfunction

  function automatic data_t sat_sum(logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(DMAX)) return data_t'(DMAX);
    if (v < SUM_W'(DMIN)) return data_t'(DMIN);
    return DATA_WIDTH'(v);
  endfunction

  // Multiply each coefficient by its operand
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      for (int j = 0; j < LANES; j++) begin
        prod_q[j] <= PROD_W'(coef_i[j]) * PROD_W'(opnd_i[j]);
      end
    end
  end

  // Rescale products, or pass the operand straight through for translation only
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      if (ctl_i.pass_en) begin
        term_d[j] = (LANE_W'(j) == ctl_i.pass_lane) ? opnd_i[j] : '0;
      end else begin
        term_d[j] = scale_sat(prod_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.term_en) term_q <= term_d;
  end

  // Sum terms and translation, clamp, subtract and clamp again
  always_comb begin
    sum_w = SUM_W'(term_q[0]) + SUM_W'(term_q[1]) + SUM_W'(term_q[2]) + SUM_W'(add_i);
    row_sat = sat_sum(sum_w);
    diff_w = SUM_W'(row_sat) - SUM_W'(sub_i);
    res_o = sat_sum(diff_w);
  end

endmodule

// ===== rtl/vvtc_top.sv =====
// Top level: sequencer, configuration registers, clip outcode and result register.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+----------------------------------------------------
//  pt_i     | in  | valid/ready  | op, coef_index, coef_value, px, py, pz, last_point
//  res_o    | out | valid/ready  | view_x, view_y, view_z, clip_code, pool_visible,
//           |     |              | last_out
//  cfg_i    | in  | valid/ready  | index, data (ready always high)
//
//  A load transaction writes its coefficient at acceptance.
//  A point runs through acceptance and 14 sequencer steps, set by eight row reads from
//  the one-row-per-cycle coefficient memory and the row unit's multiply, rescale and sum.
//  Reset clears all coefficients to zero at once through per-entry valid bits.
//  A finished result waits in the output register; the next transaction is taken
//  meanwhile, and a second point holds in its last step until the register frees.
module vertex_view_transform_clip
  import vvtc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  vvtc_in_if.sink    pt_i,
  vvtc_out_if.source res_o,
  vvtc_cfg_if.sink   cfg_i
);

  state_e st_q, st_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic run;
  logic pt_acc;
  logic coef_we;
  logic out_free;
  logic out_load;

  logic signed [CFG_WIDTH-1:0] near_z_q, far_z_q;
  logic translate_only_q;

  data_t pnt_q [LANES];
  data_t g_q [LANES];
  data_t v_q [LANES];
  data_t opos_q [LANES];
  data_t vpos_q [LANES];
  logic last_q;

  logic rd_en;
  logic [ROW_W-1:0] rd_row;
  data_t rd_data [LANES];
  row_ctl_t row_ctl;
  data_t opnd [LANES];
  data_t add_term, sub_term;
  data_t row_res;
  logic g_we, v_we;
  logic [LANE_W-1:0] res_lane;

  logic signed [CMP_W-1:0] vx_e, vy_e, vz_e, nvz_e, near_e, far_e;
  logic [CLIP_W-1:0] clip_d;
  logic [CLIP_W-1:0] acc_q, acc_new;

  logic res_valid_q;
  data_t res_x_q, res_y_q, res_z_q;
  logic [CLIP_W-1:0] res_clip_q;
  logic res_vis_q, res_last_q;

  function automatic logic in_win(logic [STEP_W-1:0] s, logic [STEP_W-1:0] base);
    return (s >= base) && (s < base + STEP_W'(LANES));
  endfunction

  // Configuration: always ready, ignore unknown indexes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_z_q         <= '0;
      far_z_q          <= CFG_WIDTH'(DMAX);
      translate_only_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_NEAR_Z:         near_z_q <= cfg_i.data;
        CFG_FAR_Z:          far_z_q <= cfg_i.data;
        CFG_TRANSLATE_ONLY: translate_only_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // State machine: next state
  assign pt_acc   = pt_i.valid && pt_i.ready;
  assign out_free = !res_valid_q || res_o.ready;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (pt_acc && pt_i.op == OP_POINT) st_d = ST_RUN;
      ST_RUN:  if (step_q == STEP_CLIP && out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // State machine: outputs
  always_comb begin
    pt_i.ready = 1'b0;
    run        = 1'b0;
    unique case (st_q)
      ST_IDLE: pt_i.ready = 1'b1;
      ST_RUN:  run = 1'b1;
      default: ;
    endcase
  end

  // Advance the step counter, hold in the last step while the result register is full
  always_comb begin
    step_d = step_q;
    if (!run) step_d = '0;
    else if (step_q != STEP_CLIP) step_d = step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
    end
  end

  // Capture the point at acceptance
  always_ff @(posedge clk_i) begin
    if (pt_acc && pt_i.op == OP_POINT) begin
      pnt_q[0] <= pt_i.px;
      pnt_q[1] <= pt_i.py;
      pnt_q[2] <= pt_i.pz;
      last_q   <= pt_i.last_point;
    end
  end

  // Coefficient memory
  assign coef_we = pt_acc && pt_i.op == OP_LOAD && pt_i.coef_index < IDX_W'(NUM_COEF);

  vvtc_coef_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (coef_we),
    .wr_row_i  (coef_row(pt_i.coef_index)),
    .wr_lane_i (coef_lane(pt_i.coef_index)),
    .wr_data_i (pt_i.coef_value),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_data_o (rd_data)
  );

  // Step decode for reads and the row unit
  always_comb begin
    rd_en             = 1'b0;
    rd_row            = ROW_OBJ;
    row_ctl           = '0;
    g_we              = 1'b0;
    v_we              = 1'b0;
    res_lane          = '0;
    add_term          = '0;
    sub_term          = '0;
    if (run) begin
      if (step_q == STEP_OPOS) begin
        rd_en  = 1'b1;
        rd_row = ROW_OPOS;
      end else if (step_q == STEP_VPOS) begin
        rd_en  = 1'b1;
        rd_row = ROW_VPOS;
      end else if (in_win(step_q, STEP_WRD)) begin
        rd_en  = 1'b1;
        rd_row = ROW_OBJ + ROW_W'(step_q - STEP_WRD);
      end else if (in_win(step_q, STEP_VRD)) begin
        rd_en  = 1'b1;
        rd_row = ROW_VIEW + ROW_W'(step_q - STEP_VRD);
      end
      row_ctl.mul_en  = in_win(step_q, STEP_WMUL) || in_win(step_q, STEP_VMUL);
      row_ctl.term_en = in_win(step_q, STEP_WTRM) || in_win(step_q, STEP_VTRM);
      if (in_win(step_q, STEP_WTRM) && translate_only_q) begin
        row_ctl.pass_en   = 1'b1;
        row_ctl.pass_lane = LANE_W'(step_q - STEP_WTRM);
      end
      if (in_win(step_q, STEP_WSUM)) begin
        g_we     = 1'b1;
        res_lane = LANE_W'(step_q - STEP_WSUM);
        add_term = opos_q[res_lane];
        sub_term = vpos_q[res_lane];
      end else if (in_win(step_q, STEP_VSUM)) begin
        v_we     = 1'b1;
        res_lane = LANE_W'(step_q - STEP_VSUM);
      end
    end
  end

  // Operands: the point for the object rows, world coordinates for the viewer rows
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      opnd[j] = (step_q < STEP_VMUL) ? pnt_q[j] : g_q[j];
    end
  end

  vvtc_row_unit u_row (
    .clk_i  (clk_i),
    .ctl_i  (row_ctl),
    .coef_i (rd_data),
    .opnd_i (opnd),
    .add_i  (add_term),
    .sub_i  (sub_term),
    .res_o  (row_res)
  );

  // Hold translations and row results
  always_ff @(posedge clk_i) begin
    if (run && step_q == STEP_OPOS + STEP_W'(1)) opos_q <= rd_data;
    if (run && step_q == STEP_VPOS + STEP_W'(1)) vpos_q <= rd_data;
    if (g_we) g_q[res_lane] <= row_res;
    if (v_we) v_q[res_lane] <= row_res;
  end

  // Clip outcode against near, far and the 90-degree frustum
  always_comb begin
    vx_e   = CMP_W'(v_q[0]);
    vy_e   = CMP_W'(v_q[1]);
    vz_e   = CMP_W'(v_q[2]);
    nvz_e  = -vz_e;
    near_e = CMP_W'(near_z_q);
    far_e  = CMP_W'(far_z_q);
    clip_d = '0;
    if (vz_e < near_e) clip_d[CLIP_BEHIND] = 1'b1;
    else if (vz_e > far_e) clip_d[CLIP_FAR] = 1'b1;
    clip_d[CLIP_RIGHT]  = vx_e > vz_e;
    clip_d[CLIP_LEFT]   = vx_e < nvz_e;
    clip_d[CLIP_BOTTOM] = vy_e > vz_e;
    clip_d[CLIP_TOP]    = vy_e < nvz_e;
  end

  assign out_load = run && step_q == STEP_CLIP && out_free;
  assign acc_new  = acc_q & clip_d;

  // Pool accumulator: restart after the last point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= ALL_CLIP;
    else if (out_load) acc_q <= last_q ? ALL_CLIP : acc_new;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else if (out_load) res_valid_q <= 1'b1;
    else if (res_o.ready) res_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_x_q    <= v_q[0];
      res_y_q    <= v_q[1];
      res_z_q    <= v_q[2];
      res_clip_q <= clip_d;
      res_vis_q  <= last_q && (acc_new == '0);
      res_last_q <= last_q;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.view_x       = res_x_q;
  assign res_o.view_y       = res_y_q;
  assign res_o.view_z       = res_z_q;
  assign res_o.clip_code    = res_clip_q;
  assign res_o.pool_visible = res_vis_q;
  assign res_o.last_out     = res_last_q;

  // Coefficients change only between points
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_we |-> st_q == ST_IDLE)
    else $error("coefficient write during a point");

  // Accumulator restarts after the last point of a pool
  a_acc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> acc_q == ALL_CLIP)
    else $error("accumulator not restarted after last point");

  // Visibility is reported only on the last point
  a_vis_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (!res_o.pool_visible || res_o.last_out))
    else $error("pool visibility on a non-last point");

  // Behind and too far are exclusive
  a_near_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.clip_code[CLIP_BEHIND] && res_o.clip_code[CLIP_FAR]))
    else $error("behind and too far both set");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |-> !out_load)
    else $error("result register overwritten");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for vertex_view_transform_clip: directed and random points checked against a predictor.
module tb_top;
  import vvtc_pkg::*;

  localparam data_t Q_MAX     = data_t'(DMAX);
  localparam data_t Q_MIN     = data_t'(DMIN);
  localparam int    OBJ_BASE  = int'(ROW_OBJ) * LANES;
  localparam int    OPOS_BASE = int'(ROW_OPOS) * LANES;
  localparam int    VIEW_BASE = int'(ROW_VIEW) * LANES;
  localparam int    VPOS_BASE = int'(ROW_VPOS) * LANES;
  localparam int    DRAIN_CYCLES = 20;

  typedef struct {
    data_t             view_x;
    data_t             view_y;
    data_t             view_z;
    logic [CLIP_W-1:0] clip_code;
    logic              pool_visible;
    logic              last_out;
  } view_result_t;

  logic clk_i;
  logic rst_ni;

  vvtc_in_if  pt_if ();
  vvtc_out_if res_if ();
  vvtc_cfg_if cfg_if ();

  vertex_view_transform_clip DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Predictor state
  longint            coef_mem [NUM_COEF];
  logic [CLIP_W-1:0] pool_and;
  longint            near_plane;
  longint            far_plane;
  logic              xlate_only;

  view_result_t pending_views [$];
  int           err_cnt;
  int           gap_pct;
  int           stall_pct;

  // Clock: period 20
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Fixed-point helpers
  function automatic data_t q(int n);
    return data_t'(longint'(n) <<< FRAC_BITS);
  endfunction

  function automatic longint sat_q(longint v);
    if (v > DMAX) return DMAX;
    if (v < DMIN) return DMIN;
    return v;
  endfunction

  // Multiply on magnitudes, truncate toward zero, saturate
  function automatic longint mul_q(longint a, longint b);
    logic   neg;
    longint mag;
    longint lim;
    neg = (a < 0) != (b < 0);
    mag = ((a < 0) ? -a : a) * ((b < 0) ? -b : b);
    mag = mag >> FRAC_BITS;
    lim = neg ? -DMIN : DMAX;
    if (mag > lim) mag = lim;
    return neg ? -mag : mag;
  endfunction

  function automatic longint dot_row(int base, longint x, longint y, longint z, longint t);
    return sat_q(mul_q(coef_mem[base], x) + mul_q(coef_mem[base + 1], y) +
                 mul_q(coef_mem[base + 2], z) + t);
  endfunction

  // Work out the view point and outcode of one point; update the pool AND
  function automatic view_result_t transform_point(data_t x, data_t y, data_t z, logic last);
    longint            wx, wy, wz, vx, vy, vz;
    logic [CLIP_W-1:0] cc;
    view_result_t      r;
    if (xlate_only) begin
      wx = sat_q(longint'(x) + coef_mem[OPOS_BASE]);
      wy = sat_q(longint'(y) + coef_mem[OPOS_BASE + 1]);
      wz = sat_q(longint'(z) + coef_mem[OPOS_BASE + 2]);
    end else begin
      wx = dot_row(OBJ_BASE,     x, y, z, coef_mem[OPOS_BASE]);
      wy = dot_row(OBJ_BASE + 3, x, y, z, coef_mem[OPOS_BASE + 1]);
      wz = dot_row(OBJ_BASE + 6, x, y, z, coef_mem[OPOS_BASE + 2]);
    end
    wx = sat_q(wx - coef_mem[VPOS_BASE]);
    wy = sat_q(wy - coef_mem[VPOS_BASE + 1]);
    wz = sat_q(wz - coef_mem[VPOS_BASE + 2]);
    vx = dot_row(VIEW_BASE,     wx, wy, wz, 0);
    vy = dot_row(VIEW_BASE + 3, wx, wy, wz, 0);
    vz = dot_row(VIEW_BASE + 6, wx, wy, wz, 0);
    // Far plane is tested only in front of the near plane
    cc = '0;
    if (vz < near_plane) cc[CLIP_BEHIND] = 1'b1;
    else if (vz > far_plane) cc[CLIP_FAR] = 1'b1;
    if (vx > vz)  cc[CLIP_RIGHT]  = 1'b1;
    if (vx < -vz) cc[CLIP_LEFT]   = 1'b1;
    if (vy > vz)  cc[CLIP_BOTTOM] = 1'b1;
    if (vy < -vz) cc[CLIP_TOP]    = 1'b1;
    pool_and = pool_and & cc;
    r.view_x       = data_t'(vx);
    r.view_y       = data_t'(vy);
    r.view_z       = data_t'(vz);
    r.clip_code    = cc;
    r.last_out     = last;
    r.pool_visible = 1'b0;
    if (last) begin
      r.pool_visible = (pool_and == '0);
      pool_and       = ALL_CLIP;
    end
    return r;
  endfunction

  // Send one transaction; valid stays high for a following item
  task automatic send_item(logic op, logic [IDX_W-1:0] idx, data_t cval,
                           data_t x, data_t y, data_t z, logic last);
    while ($urandom_range(99) < gap_pct) begin
      pt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pt_if.valid      <= 1'b1;
    pt_if.op         <= op;
    pt_if.coef_index <= idx;
    pt_if.coef_value <= cval;
    pt_if.px         <= x;
    pt_if.py         <= y;
    pt_if.pz         <= z;
    pt_if.last_point <= last;
    do @(posedge clk_i); while (!pt_if.ready);
    if (op == OP_LOAD) begin
      if (idx < NUM_COEF) coef_mem[idx] = longint'(cval);
    end else begin
      pending_views.push_back(transform_point(x, y, z, last));
    end
  endtask

  task automatic load_coef(logic [IDX_W-1:0] idx, data_t val);
    send_item(OP_LOAD, idx, val, data_t'($urandom), data_t'($urandom), data_t'($urandom),
              1'(($urandom)));
  endtask

  task automatic send_point(data_t x, data_t y, data_t z, logic last);
    send_item(OP_POINT, IDX_W'($urandom), data_t'($urandom), x, y, z, last);
  endtask

  // Hold the sender until every result is back and the block has settled
  task automatic drain_block();
    pt_if.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_WIDTH-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_NEAR_Z:         near_plane = longint'($signed(val));
      CFG_FAR_Z:          far_plane  = longint'($signed(val));
      CFG_TRANSLATE_ONLY: xlate_only = val[0];
      default: ;
    endcase
  endtask

  // Write all registers while the block is idle
  task automatic apply_config(data_t near_v, data_t far_v, logic tonly);
    drain_block();
    write_reg(CFG_NEAR_Z, near_v);
    write_reg(CFG_FAR_Z, far_v);
    write_reg(CFG_TRANSLATE_ONLY, ($urandom & 32'hFFFF_FFFE) | CFG_WIDTH'(tonly));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic data_t rand_coef();
    case ($urandom_range(15))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return data_t'($urandom);
      default: return data_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic data_t rand_coord();
    case ($urandom_range(15))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return data_t'($urandom);
      default: return data_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    endcase
  endfunction

  // Points against the cleared table give zero view and no clip bits
  task automatic test_cleared_table();
    send_point(q(3), q(-2), q(7), 1'b0);
    send_point(Q_MAX, Q_MIN, '0, 1'b1);
  endtask

  // Identity matrices, then a point inside the frustum and points past each of its sides
  task automatic test_coef_loads();
    load_coef(0, q(1));
    load_coef(4, q(1));
    load_coef(8, q(1));
    load_coef(12, q(1));
    load_coef(16, q(1));
    load_coef(20, q(1));
    send_point(q(1), q(2), q(10), 1'b0);
    send_point(q(20), '0, q(10), 1'b0);
    send_point(q(-20), q(20), q(10), 1'b0);
    send_point('0, q(-20), q(10), 1'b1);
  endtask

  // Saturating products and offsets; loads beyond the table are dropped
  task automatic test_saturation();
    load_coef(23, Q_MIN);
    load_coef(0, Q_MAX);
    load_coef(31, q(5));
    load_coef(24, q(-5));
    send_point(Q_MAX, Q_MIN, Q_MAX, 1'b1);
    load_coef(23, '0);
    load_coef(0, q(1));
  endtask

  // Near and far planes, a pool that is not visible, crossed planes and translate only
  task automatic test_clip_planes();
    apply_config(q(2), q(8), 1'b0);
    send_point('0, '0, q(1), 1'b0);
    send_point('0, '0, q(5), 1'b0);
    send_point('0, '0, q(9), 1'b1);
    send_point(q(20), '0, q(5), 1'b0);
    send_point(q(30), q(1), q(4), 1'b1);
    apply_config(q(8), q(2), 1'b1);
    load_coef(9, q(1));
    send_point(q(1), q(2), q(5), 1'b1);
  endtask

  // Pools of random points, now and then a few coefficient updates ahead of them
  task automatic run_pools(int n_items);
    int count;
    int len;
    int idx;
    logic last;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          idx = ($urandom_range(9) == 0) ? $urandom_range(NUM_COEF, 31)
                                         : $urandom_range(0, NUM_COEF - 1);
          load_coef(IDX_W'(idx), rand_coef());
          if (idx < NUM_COEF) count++;
        end
      end
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        last = (k == len - 1);
        if ($urandom_range(19) == 0) last = ~last;
        send_point(rand_coord(), rand_coord(), rand_coord(), last);
        count++;
      end
    end
  endtask

  // Random traffic over several register settings, extremes included
  task automatic test_random_traffic();
    apply_config('0, Q_MAX, 1'b0);
    run_pools(190);
    apply_config(Q_MIN, Q_MAX, 1'b1);
    run_pools(190);
    // Long stretch with no idling on either side
    gap_pct   = 0;
    stall_pct = 0;
    apply_config(q(1), q(50), 1'b0);
    run_pools(190);
    gap_pct   = 15;
    stall_pct = 15;
    apply_config(Q_MAX, Q_MIN, 1'b0);
    run_pools(190);
    apply_config(rand_coord(), rand_coord(), 1'($urandom));
    run_pools(190);
  endtask

  // Receiver stalls at random
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic cmp_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Compare each result transaction with the oldest expected view
  always @(posedge clk_i) begin : check_views
    view_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_views.size() == 0) begin
        $error("result with no expected view waiting");
        err_cnt++;
      end else begin
        want = pending_views.pop_front();
        cmp_field("view_x", want.view_x, res_if.view_x);
        cmp_field("view_y", want.view_y, res_if.view_y);
        cmp_field("view_z", want.view_z, res_if.view_z);
        cmp_field("clip_code", want.clip_code, res_if.clip_code);
        cmp_field("pool_visible", want.pool_visible, res_if.pool_visible);
        cmp_field("last_out", want.last_out, res_if.last_out);
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni            = 1'b0;
    pt_if.valid       = 1'b0;
    pt_if.op          = OP_LOAD;
    pt_if.coef_index  = '0;
    pt_if.coef_value  = '0;
    pt_if.px          = '0;
    pt_if.py          = '0;
    pt_if.pz          = '0;
    pt_if.last_point  = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_NEAR_Z;
    cfg_if.data       = '0;
    res_if.ready      = 1'b0;
    err_cnt           = 0;
    gap_pct           = 15;
    stall_pct         = 15;
    foreach (coef_mem[i]) coef_mem[i] = 0;
    pool_and   = ALL_CLIP;
    near_plane = 0;
    far_plane  = DMAX;
    xlate_only = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cleared_table();
    test_coef_loads();
    test_saturation();
    test_clip_planes();
    test_random_traffic();

    pt_if.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
